>>> design/pcs_pkg.sv
// Shared types, constants and helpers for the pressure count calibration block.
// Used by pcs_ctrl, pcs_dp and the top level pressure_counts_calibrate_smooth.
// Depends on nothing.
`default_nettype none

package pcs_pkg;

    // Fixed-point fraction bits of the pressure outputs.
    localparam int FRAC_BITS = 8;

    // Field and register widths.
    localparam int COUNT_W    = 14;
    localparam int PRS_W      = 12;
    localparam int WGT_W      = 9;
    localparam int OUT_W      = 20;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths.
    localparam int DIFF_W     = COUNT_W + 1;
    localparam int PSPAN_W    = PRS_W + 1;
    localparam int PROD_W     = DIFF_W + PSPAN_W;
    localparam int PMAG_W     = PROD_W - 1;
    localparam int NUM_W      = PMAG_W + FRAC_BITS;
    localparam int DIV_W      = NUM_W + (NUM_W % 2);
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int QS_W       = DIV_W + 1;
    localparam int V_W        = DIV_W + 2;

    // Smoothing arithmetic: Q8 weight.
    localparam int W_SHIFT    = 8;
    localparam int MIX_W      = OUT_W + WGT_W + 1;
    localparam int SUM_W      = MIX_W + 1;
    localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1 << W_SHIFT);

    // A converted value must lie above this to be stored.
    localparam logic signed [V_W-1:0] REJECT_LIMIT = V_W'(-10 * (1 << FRAC_BITS));
    localparam logic signed [V_W-1:0] OUT_MAX_V = V_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [V_W-1:0] OUT_MIN_V = V_W'(-(1 << (OUT_W - 1)));

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] COUNT_AT_MAX_RST    = COUNT_W'(14745);
    localparam logic [COUNT_W-1:0] COUNT_AT_MIN_RST    = COUNT_W'(1638);
    localparam logic [PRS_W-1:0]   PRESSURE_AT_MAX_RST = PRS_W'(100);
    localparam logic [PRS_W-1:0]   PRESSURE_AT_MIN_RST = PRS_W'(0);
    localparam logic [WGT_W-1:0]   SMOOTHING_WEIGHT_RST = W_ONE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_AT_MAX     = 3'd0,
        CFG_COUNT_AT_MIN     = 3'd1,
        CFG_PRESSURE_AT_MAX  = 3'd2,
        CFG_PRESSURE_AT_MIN  = 3'd3,
        CFG_SMOOTHING_WEIGHT = 3'd4
    } pcs_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_SIGN,
        ST_ACC,
        ST_SMUL,
        ST_FIN,
        ST_OUT
    } pcs_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic prep;
        logic div_step;
        logic sign;
        logic acc;
        logic smul;
        logic fin;
        logic load_out;
    } pcs_cmd_t;

    typedef struct packed {
        logic div_last;
    } pcs_status_t;

    // Clamp a wide signed value to the output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [V_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX_V) begin
            r = OUT_MAX_V[OUT_W-1:0];
        end else if (v < OUT_MIN_V) begin
            r = OUT_MIN_V[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/pcs_ctrl.sv
// Sequencing state machine of the pressure count calibration block.
// Depends on pcs_pkg; drives pcs_dp through a command struct.
`default_nettype none

module pcs_ctrl
    import pcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire pcs_status_t status,
    output pcs_cmd_t         cmd
);

    pcs_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (status.div_last) state_next = ST_SIGN;
            ST_SIGN: state_next = ST_ACC;
            ST_ACC:  state_next = ST_SMUL;
            ST_SMUL: state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL:  cmd.mul      = 1'b1;
            ST_PREP: cmd.prep     = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_SIGN: cmd.sign     = 1'b1;
            ST_ACC:  cmd.acc      = 1'b1;
            ST_SMUL: cmd.smul     = 1'b1;
            ST_FIN:  cmd.fin      = 1'b1;
            ST_OUT:  cmd.load_out = out_free;
            default: cmd          = '0;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

>>> design/pcs_dp.sv
// Datapath of the pressure count calibration block: configuration registers,
// span multiply, two-bit-per-cycle divider, acceptance, smoothing and output word.
// Depends on pcs_pkg; steered by pcs_ctrl.
`default_nettype none

module pcs_dp
    import pcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [BYTE_W-1:0]     high_byte,
    input  wire logic [BYTE_W-1:0]     low_byte,
    input  wire pcs_cmd_t              cmd,
    output pcs_status_t                status,
    output logic signed [OUT_W-1:0]    pressure_q8,
    output logic signed [OUT_W-1:0]    smoothed_q8,
    output logic                       reading_accepted
);

    // Configuration registers.
    logic [COUNT_W-1:0]      cmax_reg, cmin_reg;
    logic signed [PRS_W-1:0] pmax_reg, pmin_reg;
    logic [WGT_W-1:0]        wgt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmax_reg <= COUNT_AT_MAX_RST;
            cmin_reg <= COUNT_AT_MIN_RST;
            pmax_reg <= PRESSURE_AT_MAX_RST;
            pmin_reg <= PRESSURE_AT_MIN_RST;
            wgt_reg  <= SMOOTHING_WEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COUNT_AT_MAX:     cmax_reg <= cfg_data[COUNT_W-1:0];
                CFG_COUNT_AT_MIN:     cmin_reg <= cfg_data[COUNT_W-1:0];
                CFG_PRESSURE_AT_MAX:  pmax_reg <= cfg_data[PRS_W-1:0];
                CFG_PRESSURE_AT_MIN:  pmin_reg <= cfg_data[PRS_W-1:0];
                CFG_SMOOTHING_WEIGHT: wgt_reg  <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers.
    logic [COUNT_W-1:0]        count_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DIFF_W-1:0]  cspan_reg;
    logic [DIV_W-1:0]          quo_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [COUNT_W-1:0]        den_reg;
    logic                      neg_reg;
    logic                      zero_reg;
    logic [STEP_CNT_W-1:0]     step_cnt_reg;
    logic signed [QS_W-1:0]    qs_reg;
    logic signed [OUT_W-1:0]   held_reg, prev_reg, smoothed_reg;
    logic                      first_reg;
    logic                      acc_reg;
    logic signed [MIX_W-1:0]   m1_reg, m2_reg;
    logic signed [OUT_W-1:0]   out_p_reg, out_s_reg;
    logic                      out_a_reg;

    // Combinational terms.
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PSPAN_W-1:0] pspan;
    logic signed [PROD_W-1:0]  prod_abs;
    logic signed [DIFF_W-1:0]  cspan_abs;
    logic [DIV_W-1:0]          quo_next;
    logic [COUNT_W-1:0]        rem_next;
    logic signed [V_W-1:0]     v;
    logic                      accepted;
    logic [WGT_W-1:0]          w_eff;
    logic [WGT_W-1:0]          w_rest;
    logic signed [SUM_W-1:0]   mix_sum;
    logic signed [SUM_W-1:0]   mix_shift;

    assign diff  = $signed({1'b0, count_reg}) - $signed({1'b0, cmin_reg});
    assign pspan = PSPAN_W'(pmax_reg) - PSPAN_W'(pmin_reg);

    assign prod_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign cspan_abs = cspan_reg[DIFF_W-1] ? -cspan_reg : cspan_reg;

    // Two restoring division steps per cycle.
    always_comb begin
        logic [COUNT_W:0]   r;
        logic [DIV_W-1:0]   q;
        logic [COUNT_W-1:0] rm;
        q  = quo_reg;
        rm = rem_reg;
        for (int i = 0; i < 2; i++) begin
            r = {rm, q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg}) begin
                r    = r - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            rm = r[COUNT_W-1:0];
        end
        quo_next = q;
        rem_next = rm;
    end

    assign v        = V_W'(qs_reg) + (V_W'(pmin_reg) <<< FRAC_BITS);
    assign accepted = v > REJECT_LIMIT;

    assign w_eff  = (wgt_reg > W_ONE) ? W_ONE : wgt_reg;
    assign w_rest = W_ONE - w_eff;

    assign mix_sum   = SUM_W'(m1_reg) + SUM_W'(m2_reg);
    assign mix_shift = mix_sum >>> W_SHIFT;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            count_reg <= {high_byte[COUNT_W-BYTE_W-1:0], low_byte};
        end
        if (cmd.mul) begin
            prod_reg  <= diff * pspan;
            cspan_reg <= $signed({1'b0, cmax_reg}) - $signed({1'b0, cmin_reg});
        end
        if (cmd.prep) begin
            quo_reg      <= DIV_W'({prod_abs[PMAG_W-1:0], {FRAC_BITS{1'b0}}});
            rem_reg      <= '0;
            den_reg      <= cspan_abs[COUNT_W-1:0];
            neg_reg      <= prod_reg[PROD_W-1] ^ cspan_reg[DIFF_W-1];
            zero_reg     <= (cspan_reg == '0);
            step_cnt_reg <= STEP_CNT_W'(DIV_STEPS - 1);
        end
        if (cmd.div_step) begin
            quo_reg      <= quo_next;
            rem_reg      <= rem_next;
            step_cnt_reg <= step_cnt_reg - 1'b1;
        end
        if (cmd.sign) begin
            if (zero_reg) begin
                qs_reg <= '0;
            end else if (neg_reg) begin
                qs_reg <= -$signed({1'b0, quo_reg});
            end else begin
                qs_reg <= $signed({1'b0, quo_reg});
            end
        end
        if (cmd.acc) begin
            prev_reg <= held_reg;
            acc_reg  <= accepted;
        end
        if (cmd.smul) begin
            m1_reg <= $signed({1'b0, w_eff}) * held_reg;
            m2_reg <= $signed({1'b0, w_rest}) * prev_reg;
        end
        if (cmd.load_out) begin
            out_p_reg <= held_reg;
            out_s_reg <= smoothed_reg;
            out_a_reg <= acc_reg;
        end
    end

    // Architectural state of the filter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            smoothed_reg <= '0;
            first_reg    <= 1'b1;
        end else begin
            if (cmd.acc && accepted) begin
                held_reg <= sat_out(v);
            end
            if (cmd.fin) begin
                if (!first_reg) begin
                    smoothed_reg <= sat_out(V_W'(mix_shift));
                end
                first_reg <= 1'b0;
            end
        end
    end

    assign status.div_last  = (step_cnt_reg == '0);
    assign pressure_q8      = out_p_reg;
    assign smoothed_q8      = out_s_reg;
    assign reading_accepted = out_a_reg;

endmodule

`default_nettype wire

>>> design/pressure_counts_calibrate_smooth.sv
// Top level of the pressure count calibration and smoothing block.
// Depends on pcs_pkg, pcs_ctrl and pcs_dp.
//
// Each input word carries one two-byte sensor reading. The two status bits at
// the top of the high byte are dropped, leaving a 14-bit count, which is mapped
// linearly from the configured count span onto the configured pressure span in
// signed Q8. A value not above -10 is rejected and the previous pressure is
// held; from the second reading on, the smoothed output is the weighted mix of
// the new and the previous held pressure. One reading is processed at a time.
// After the input word is accepted, the reading passes through the span multiply,
// the divider preparation, the restoring divider (two quotient bits a cycle over
// a 36-bit dividend), then sign, accept, smoothing multiply, smoothing add and
// output load. A reading waits in the output load step only while an earlier
// word still waits at the output. The next reading is accepted as soon as the
// finished word sits in the output register, even if that word is not yet
// taken. Configuration registers are written through the plain write port and
// should only be changed while the block is idle.
`default_nettype none

module pressure_counts_calibrate_smooth
    import pcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // high_byte [7:0], low_byte [15:8]
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [2*OUT_W-1:0]         m_tdata,  // pressure_q8 [19:0], smoothed_q8 [39:20]
    output logic                       m_tuser   // reading_accepted
);

    pcs_cmd_t                cmd;
    pcs_status_t             status;
    logic signed [OUT_W-1:0] pressure_q8;
    logic signed [OUT_W-1:0] smoothed_q8;
    logic                    reading_accepted;

    pcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcs_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .high_byte        (s_tdata[BYTE_W-1:0]),
        .low_byte         (s_tdata[2*BYTE_W-1:BYTE_W]),
        .cmd              (cmd),
        .status           (status),
        .pressure_q8      (pressure_q8),
        .smoothed_q8      (smoothed_q8),
        .reading_accepted (reading_accepted)
    );

    assign m_tdata = {smoothed_q8, pressure_q8};
    assign m_tuser = reading_accepted;

    // A reading flagged as accepted is always above the rejection threshold.
    a_accepted_above_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> V_W'($signed(m_tdata[OUT_W-1:0])) > REJECT_LIMIT)
        else $error("accepted reading at or below the rejection threshold");

    // Only one reading is in flight: taking a word closes the input side.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after a word was taken");

    // A result never appears the cycle after a word is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised directly after input word");

endmodule

`default_nettype wire
